### src/awcr_pkg.sv
package awcr_pkg;

  // Wall table depth and the widths that follow from it.
  localparam int MAX_WALLS = 64;
  localparam int WALL_AW   = $clog2(MAX_WALLS);
  localparam int WALL_CW   = $clog2(MAX_WALLS + 1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_WALL_COUNT = 2'd0;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

  // Commands carried by an input item.
  localparam logic CMD_WRITE_WALL = 1'b0;
  localparam logic CMD_MOVE       = 1'b1;

  typedef struct packed {
    logic               command;
    logic [5:0]         wall_index;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] granted_x;
    logic signed [15:0] granted_y;
    logic signed [15:0] new_left;
    logic signed [15:0] new_top;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
  } wall_t;

  // Unmoved player rectangle with its far edges already summed.
  typedef struct packed {
    logic signed [17:0] left;
    logic signed [17:0] top;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
    logic               has_area;
  } player_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  function automatic logic signed [17:0] sx18(input logic [15:0] v);
    sx18 = $signed({{2{v[15]}}, v});
  endfunction

  function automatic logic signed [17:0] zx18(input logic [14:0] v);
    zx18 = $signed({3'b000, v});
  endfunction

endpackage

### src/awcr_wall_ram.sv
module awcr_wall_ram (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [awcr_pkg::WALL_AW-1:0] wr_addr,
  input  awcr_pkg::wall_t        wr_data,
  input  logic                   rd_en,
  input  logic [awcr_pkg::WALL_AW-1:0] rd_addr,
  output awcr_pkg::wall_t        rd_data
);
  import awcr_pkg::*;

  wall_t mem [MAX_WALLS];
  wall_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/awcr_step_unit.sv
module awcr_step_unit (
  input  awcr_pkg::player_t  ply,
  input  awcr_pkg::wall_t    wall,
  input  logic [14:0]        map_w,
  input  logic [14:0]        map_h,
  input  logic signed [15:0] mx_in,
  input  logic signed [15:0] my_in,
  output logic signed [15:0] mx_out,
  output logic signed [15:0] my_out
);
  import awcr_pkg::*;

  logic signed [17:0] mx, my;
  logic signed [17:0] nl, nt, nr, nb;
  logic signed [17:0] wl, wt, wr, wb;
  logic               out_x, out_y;
  logic               overlap, xspan, yspan, block_x, block_y;

  always_comb begin
    mx = sx18(mx_in);
    my = sx18(my_in);

    // Next rectangle from the current movement.
    nl = ply.left + mx;
    nr = ply.right + mx;
    nt = ply.top + my;
    nb = ply.bottom + my;

    wl = sx18(wall.left);
    wt = sx18(wall.top);
    wr = wl + zx18(wall.width);
    wb = wt + zx18(wall.height);

    out_y = (nb > zx18(map_h)) || nt[17];
    out_x = (nr > zx18(map_w)) || nl[17];

    // Strict overlap: both rectangles need area, and each edge pair crosses.
    overlap = ply.has_area && (wall.width != '0) && (wall.height != '0) &&
              (wl < nr) && (nl < wr) && (wt < nb) && (nt < wb);

    xspan = (ply.left < wr) && (ply.right > wl);
    yspan = (ply.top < wb) && (ply.bottom > wt);

    block_y = xspan && (((ply.top < wt) && (ply.bottom < wb)) ||
                        ((ply.top > wt) && (ply.bottom > wb)));
    block_x = yspan && (((ply.left < wl) && (ply.right < wr)) ||
                        ((ply.left > wl) && (ply.right > wr)));

    mx_out = (out_x || (overlap && block_x)) ? '0 : mx_in;
    my_out = (out_y || (overlap && block_y)) ? '0 : my_in;
  end

endmodule

### src/aabb_wall_collision_resolver.sv
// A move item is taken in S_IDLE. In S_RUN the single step unit checks one wall per
// cycle behind the registered table read, over wall_count clamped to the table depth
// (no reads with no walls), and a last evaluation drains the read pipeline. S_EMIT
// then loads the output register and returns to S_IDLE to take the next item; a new
// item is not accepted until the move is through. A result still waiting on out_ready
// holds the next move in S_EMIT. Write items leave the sequencer in S_IDLE.
// Reset (synchronous, rst_n low) idles the sequencer, drops out_valid and sets
// wall_count to 0 and both map bounds to 32767; the wall table is not cleared.
module aabb_wall_collision_resolver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  awcr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output awcr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_wdata
);
  import awcr_pkg::*;

  // Configuration registers.
  logic [6:0]  wall_count_r;
  logic [14:0] map_w_r;
  logic [14:0] map_h_r;

  // Sequencer state and move context.
  state_t             state_r, state_nxt;
  logic [WALL_CW-1:0] idx_r, idx_nxt;
  logic [WALL_CW-1:0] n_r, n_nxt;
  logic               eval_vld_r, eval_vld_nxt;
  player_t            ply_r, ply_nxt;
  logic signed [15:0] mx_r, mx_nxt;
  logic signed [15:0] my_r, my_nxt;

  // Output register, which lets a new item in while a result waits.
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               accept, accept_move, ram_we, ram_re;
  logic [WALL_CW-1:0] n_clamped;
  wall_t              wall_wr, wall_rd;
  logic signed [15:0] step_mx, step_my;
  logic signed [17:0] sum_x, sum_y;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign accept_move = accept && (in_data.command == CMD_MOVE);

  // A write outside the table is dropped.
  assign ram_we = accept && (in_data.command == CMD_WRITE_WALL) &&
                  ({1'b0, in_data.wall_index} < 7'(MAX_WALLS));
  assign ram_re = (state_r == S_RUN) && (idx_r < n_r);

  assign wall_wr = '{left:   in_data.rect_left,
                     top:    in_data.rect_top,
                     width:  in_data.rect_width,
                     height: in_data.rect_height};

  assign n_clamped = (wall_count_r > 7'(MAX_WALLS)) ? WALL_CW'(MAX_WALLS)
                                                     : WALL_CW'(wall_count_r);

  awcr_wall_ram u_wall_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_data.wall_index[WALL_AW-1:0]),
    .wr_data (wall_wr),
    .rd_en   (ram_re),
    .rd_addr (idx_r[WALL_AW-1:0]),
    .rd_data (wall_rd)
  );

  // The shared step unit applies one wall to the running movement.
  awcr_step_unit u_step (
    .ply    (ply_r),
    .wall   (wall_rd),
    .map_w  (map_w_r),
    .map_h  (map_h_r),
    .mx_in  (mx_r),
    .my_in  (my_r),
    .mx_out (step_mx),
    .my_out (step_my)
  );

  // Final position sums, saturated to 16 bits when the result is loaded.
  assign sum_x = ply_r.left + sx18(mx_r);
  assign sum_y = ply_r.top + sx18(my_r);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    eval_vld_nxt  = 1'b0;
    ply_nxt       = ply_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept_move) begin
          // Capture the unmoved player with its far edges precomputed.
          ply_nxt.left     = sx18(in_data.rect_left);
          ply_nxt.top      = sx18(in_data.rect_top);
          ply_nxt.right    = sx18(in_data.rect_left) + zx18(in_data.rect_width);
          ply_nxt.bottom   = sx18(in_data.rect_top) + zx18(in_data.rect_height);
          ply_nxt.has_area = (in_data.rect_width != '0) && (in_data.rect_height != '0);
          mx_nxt           = in_data.step_x;
          my_nxt           = in_data.step_y;
          idx_nxt          = '0;
          n_nxt            = n_clamped;
          state_nxt        = S_RUN;
        end
      end
      S_RUN: begin
        // Each table read is registered, so the step unit applies a wall in the cycle after its read.
        if (ram_re) begin
          idx_nxt      = idx_r + 1'b1;
          eval_vld_nxt = 1'b1;
        end
        if (eval_vld_r) begin
          mx_nxt = step_mx;
          my_nxt = step_my;
        end
        if (!ram_re && !eval_vld_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.granted_x = mx_r;
          out_data_nxt.granted_y = my_r;
          out_data_nxt.new_left  = sat16(sum_x);
          out_data_nxt.new_top   = sat16(sum_y);
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      n_r         <= '0;
      eval_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      eval_vld_r  <= eval_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ply_r      <= ply_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_count_r <= '0;
      map_w_r      <= 15'h7fff;
      map_h_r      <= 15'h7fff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WALL_COUNT: wall_count_r <= cfg_wdata[6:0];
        CFG_MAP_WIDTH:  map_w_r      <= cfg_wdata;
        CFG_MAP_HEIGHT: map_h_r      <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The step unit only ever sees read data while a move is running.
  a_eval_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    eval_vld_r |-> (state_r == S_RUN))
    else $error("wall evaluated outside a move");

  // The wall pointer never runs past the clamped wall count.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (idx_r <= n_r) && (n_r <= WALL_CW'(MAX_WALLS)))
    else $error("wall pointer out of range");

  // A write item never starts the sequencer.
  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.command == CMD_WRITE_WALL)) |=> (state_r == S_IDLE))
    else $error("write item left the idle state");

  // A move always leaves idle and is later loaded into the output register.
  a_move_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept_move |=> (state_r == S_RUN))
    else $error("move item did not start");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && (!out_valid_r || out_ready)) |=>
      (out_valid_r && (state_r == S_IDLE)))
    else $error("finished move not loaded into the output register");

endmodule
